// File: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros used by full_linear_convolution.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// prop must hold at every clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// cond must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

// File: design/flc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flc_pkg
// Shared constants and types of the full linear convolution filter.
// ----------------------------------------------------------------------------
package flc_pkg;

    localparam int MAX_TAPS_DEF    = 8;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int COEF_BITS       = 16;
    localparam int OUT_BITS        = 35;
    localparam int TAP_CNT_BITS    = 4;
    localparam int COEFS_PER_REG   = 4;
    localparam int CFG_IDX_BITS    = 2;
    localparam int CFG_DATA_BITS   = 64;

    // configuration register indexes
    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_TAP_COUNT = 2'd0,
        CFG_COEF_LOW  = 2'd1,
        CFG_COEF_HIGH = 2'd2
    } cfg_reg_t;

    // per-cycle control broadcast along the cell row
    typedef struct packed {
        logic adv;    // pipeline advances this cycle
        logic shift;  // a sample enters the row
        logic clear;  // last tick of a signal: empty the delay line
    } cell_ctrl_t;

endpackage

// File: design/full_linear_convolution.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// full_linear_convolution
// Direct-form FIR giving the full linear convolution of a sample stream.
// ----------------------------------------------------------------------------
// Takes one sample per cycle while in_ready is high and gives one result per
// sample; a sample marked final_sample also produces a tail of taps_eff-1
// results (taps_eff is the tap count saturated into 1..MAX_TAPS) computed
// with zeros shifted in, the last one flagged by final_output, after which
// the delay line is empty for the next signal. While the tail is produced
// in_ready is low, since the cell row takes one tick per cycle in which the
// pipeline advances. out_valid rises once the accepting edge has loaded the
// product register in each cell, the sum has passed each adder tree level
// and then the output register. The whole pipeline advances while the
// output register is empty or being drained, so in_ready follows out_ready
// in the same cycle. Configuration writes are always accepted (cfg_ready is
// tied high) and must only be made with no item in flight.
// conv_value is the exact sum of the products, modulo 2^35.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module full_linear_convolution #(
    parameter int MAX_TAPS    = flc_pkg::MAX_TAPS_DEF,
    parameter int SAMPLE_BITS = flc_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // configuration write channel
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [flc_pkg::CFG_IDX_BITS-1:0]      cfg_index,
    input  logic [flc_pkg::CFG_DATA_BITS-1:0]     cfg_data,
    // sample items
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [SAMPLE_BITS-1:0]         sample,
    input  logic                                  final_sample,
    // result items
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [flc_pkg::OUT_BITS-1:0]   conv_value,
    output logic                                  final_output
);

    localparam int COEF_BITS = flc_pkg::COEF_BITS;
    localparam int OUT_BITS  = flc_pkg::OUT_BITS;
    localparam int PROD_W    = SAMPLE_BITS + COEF_BITS;
    localparam int LEVELS    = $clog2(MAX_TAPS);
    localparam int SUM_W     = PROD_W + LEVELS;
    localparam int ACC_W     = (SUM_W > OUT_BITS) ? SUM_W : OUT_BITS;
    localparam int TAPS_W    = $clog2(MAX_TAPS + 1);
    localparam int CNT_W     = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [flc_pkg::TAP_CNT_BITS-1:0]  tap_count_reg;
    logic [flc_pkg::CFG_DATA_BITS-1:0] coef_low_reg;
    logic [flc_pkg::CFG_DATA_BITS-1:0] coef_high_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_count_reg <= flc_pkg::TAP_CNT_BITS'(1);
            coef_low_reg  <= '0;
            coef_high_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (flc_pkg::cfg_reg_t'(cfg_index))
                flc_pkg::CFG_TAP_COUNT: tap_count_reg <= cfg_data[flc_pkg::TAP_CNT_BITS-1:0];
                flc_pkg::CFG_COEF_LOW:  coef_low_reg  <= cfg_data;
                flc_pkg::CFG_COEF_HIGH: coef_high_reg <= cfg_data;
                default: ;  // index beyond the register list: ignored
            endcase
        end
    end

    // tap count saturated into 1..MAX_TAPS
    logic [TAPS_W-1:0] taps_eff;

    always_comb
    begin
        if (tap_count_reg == '0)
        begin
            taps_eff = TAPS_W'(1);
        end
        else if (tap_count_reg > flc_pkg::TAP_CNT_BITS'(MAX_TAPS))
        begin
            taps_eff = TAPS_W'(MAX_TAPS);
        end
        else
        begin
            taps_eff = TAPS_W'(tap_count_reg);
        end
    end

    // ------------------------------------------------------------------
    // Front-end sequencer: one tick per cycle while the pipeline advances,
    // either a new item or a tail tick with a zero sample after a final item.
    // ------------------------------------------------------------------
    logic                      out_valid_reg;
    logic                      adv;
    logic                      in_fire;
    logic                      tail_tick;
    logic                      tick;
    logic                      tick_final;
    logic [CNT_W-1:0]          tail_cnt_reg;
    logic [CNT_W-1:0]          tail_cnt_next;
    logic signed [SAMPLE_BITS-1:0] cur;
    flc_pkg::cell_ctrl_t       ctrl;

    assign adv       = !out_valid_reg || out_ready;
    assign in_ready  = adv && (tail_cnt_reg == '0);
    assign in_fire   = in_valid && in_ready;
    assign tail_tick = adv && (tail_cnt_reg != '0);
    assign tick      = in_fire || tail_tick;
    assign cur       = tail_tick ? '0 : sample;

    always_comb
    begin
        tail_cnt_next = tail_cnt_reg;
        tick_final    = 1'b0;
        if (tail_tick)
        begin
            tail_cnt_next = tail_cnt_reg - 1'b1;
            tick_final    = (tail_cnt_reg == CNT_W'(1));
        end
        else if (in_fire && final_sample)
        begin
            tail_cnt_next = CNT_W'(taps_eff - 1'b1);
            tick_final    = (taps_eff == TAPS_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tail_cnt_reg <= '0;
        end
        else
        begin
            tail_cnt_reg <= tail_cnt_next;
        end
    end

    assign ctrl.adv   = adv;
    assign ctrl.shift = tick;
    assign ctrl.clear = tick_final;

    // ------------------------------------------------------------------
    // Cell row: x_tap[k] is the sample at delay k for the current tick
    // ------------------------------------------------------------------
    logic signed [SAMPLE_BITS-1:0] x_tap [MAX_TAPS];
    logic signed [SAMPLE_BITS-1:0] dl    [MAX_TAPS];
    logic signed [PROD_W-1:0]      prod  [MAX_TAPS];
    logic signed [ACC_W-1:0]       leaf  [MAX_TAPS];
    logic signed [ACC_W-1:0]       sum;
    logic                          dl_any;

    genvar k;
    generate
        for (k = 0; k < MAX_TAPS; k++)
        begin : g_tap
            logic signed [COEF_BITS-1:0] coef;

            if (k < flc_pkg::COEFS_PER_REG)
            begin : g_lo
                assign coef = coef_low_reg[k*COEF_BITS +: COEF_BITS];
            end
            else
            begin : g_hi
                assign coef = coef_high_reg[(k-flc_pkg::COEFS_PER_REG)*COEF_BITS +: COEF_BITS];
            end

            if (k == 0)
            begin : g_head
                assign x_tap[k] = cur;
            end
            else
            begin : g_link
                assign x_tap[k] = dl[k-1];
            end

            flc_cell #(
                .SAMPLE_BITS (SAMPLE_BITS),
                .KEEP        (k < MAX_TAPS - 1)
            ) u_cell (
                .clk    (clk),
                .rst_n  (rst_n),
                .ctrl   (ctrl),
                .active (TAPS_W'(k) < taps_eff),
                .coef   (coef),
                .x_in   (x_tap[k]),
                .x_out  (dl[k]),
                .prod   (prod[k])
            );

            assign leaf[k] = ACC_W'(prod[k]);
        end
    endgenerate

    always_comb
    begin
        dl_any = 1'b0;
        for (int j = 0; j < MAX_TAPS; j++)
        begin
            dl_any = dl_any | (|dl[j]);
        end
    end

    flc_adder_tree #(
        .N_IN  (MAX_TAPS),
        .WIDTH (ACC_W)
    ) u_tree (
        .clk  (clk),
        .en   (adv),
        .leaf (leaf),
        .sum  (sum)
    );

    // ------------------------------------------------------------------
    // Valid / final flags tracking the product stage and tree levels
    // ------------------------------------------------------------------
    logic [LEVELS:0] vld_reg;
    logic [LEVELS:0] fin_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            fin_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg[0] <= tick;
            fin_reg[0] <= tick_final;
            for (int j = 1; j <= LEVELS; j++)
            begin
                vld_reg[j] <= vld_reg[j-1];
                fin_reg[j] <= fin_reg[j-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic signed [OUT_BITS-1:0] conv_value_reg;
    logic                       final_output_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= vld_reg[LEVELS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            conv_value_reg   <= sum[OUT_BITS-1:0];
            final_output_reg <= fin_reg[LEVELS];
        end
    end

    assign out_valid    = out_valid_reg;
    assign conv_value   = conv_value_reg;
    assign final_output = final_output_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `ASSERT_CLK(a_dl_cleared, clk, rst_n, (tick && tick_final) |=> !dl_any)
    `ASSERT_CLK(a_tail_hold, clk, rst_n, (tail_cnt_reg != '0 && !adv) |=> $stable(tail_cnt_reg))
    `ASSERT_NEVER(a_tail_range, clk, rst_n, tail_cnt_reg > CNT_W'(MAX_TAPS - 1))

endmodule

// File: design/flc_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flc_cell
// One tap: forms the registered product and, but for the last tap, holds one delay-line sample.
// ----------------------------------------------------------------------------
module flc_cell #(
    parameter int  SAMPLE_BITS = flc_pkg::SAMPLE_BITS_DEF,
    parameter bit  KEEP        = 1'b1,
    localparam int PROD_W      = SAMPLE_BITS + flc_pkg::COEF_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  flc_pkg::cell_ctrl_t               ctrl,
    input  logic                              active,
    input  logic signed [flc_pkg::COEF_BITS-1:0] coef,
    input  logic signed [SAMPLE_BITS-1:0]     x_in,
    output logic signed [SAMPLE_BITS-1:0]     x_out,
    output logic signed [PROD_W-1:0]          prod
);

    logic signed [PROD_W-1:0] full;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [PROD_W-1:0] prod_reg;

    assign full      = x_in * coef;
    assign prod_next = active ? full : '0;

    always_ff @(posedge clk)
    begin
        if (ctrl.adv)
        begin
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

    generate
        if (KEEP)
        begin : g_store
            logic signed [SAMPLE_BITS-1:0] d_reg;
            logic signed [SAMPLE_BITS-1:0] d_next;

            assign d_next = ctrl.clear ? '0 : x_in;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    d_reg <= '0;
                end
                else if (ctrl.adv && ctrl.shift)
                begin
                    d_reg <= d_next;
                end
            end

            assign x_out = d_reg;
        end
        else
        begin : g_end
            // last tap: nothing further down the line
            assign x_out = '0;
        end
    endgenerate

endmodule

// File: design/flc_adder_tree.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flc_adder_tree
// Registered binary adder tree (a plain wire for one input), one level per cycle while en is high, heap-indexed nodes.
// ----------------------------------------------------------------------------
module flc_adder_tree #(
    parameter int N_IN  = flc_pkg::MAX_TAPS_DEF,
    parameter int WIDTH = flc_pkg::OUT_BITS
) (
    input  logic                    clk,
    input  logic                    en,
    input  logic signed [WIDTH-1:0] leaf [N_IN],
    output logic signed [WIDTH-1:0] sum
);

    localparam int LEVELS = $clog2(N_IN);
    localparam int LEAVES = 1 << LEVELS;

    logic signed [WIDTH-1:0] leaf_w [LEAVES];

    genvar i;
    generate
        for (i = 0; i < LEAVES; i++)
        begin : g_leaf
            if (i < N_IN)
            begin : g_used
                assign leaf_w[i] = leaf[i];
            end
            else
            begin : g_pad
                assign leaf_w[i] = '0;
            end
        end

        if (LEVELS == 0)
        begin : g_single
            assign sum = leaf_w[0];
        end
        else
        begin : g_tree
            // node i has children 2i and 2i+1; indexes >= LEAVES are leaves
            logic signed [WIDTH-1:0] node_reg [1:LEAVES-1];

            for (i = 1; i < LEAVES; i++)
            begin : g_node
                if (2 * i >= LEAVES)
                begin : g_bottom
                    always_ff @(posedge clk)
                    begin
                        if (en)
                        begin
                            node_reg[i] <= leaf_w[2*i-LEAVES] + leaf_w[2*i+1-LEAVES];
                        end
                    end
                end
                else
                begin : g_inner
                    always_ff @(posedge clk)
                    begin
                        if (en)
                        begin
                            node_reg[i] <= node_reg[2*i] + node_reg[2*i+1];
                        end
                    end
                end
            end

            assign sum = node_reg[1];
        end
    endgenerate

endmodule

// File: sim/full_linear_convolution_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// full_linear_convolution_tb
// Self-checking bench for the full linear convolution FIR filter.
// ----------------------------------------------------------------------------
// Drives sample items through the valid/ready input, takes results through
// the valid/ready output with random backpressure, and checks every result
// against an in-bench FIR predictor that keeps its own delay line, tap count
// and coefficients. Registers are rewritten between phases, only with the
// pipeline drained. A directed part hits the coefficient and sample extremes,
// tap count saturation, single tap signals, a tap change inside a signal and
// a write to the unused register index. Random signals follow.
// ----------------------------------------------------------------------------
module full_linear_convolution_tb;

    localparam int  PIPE_LAT   = 2 + $clog2(flc_pkg::MAX_TAPS_DEF);
    localparam int  HIST_DEPTH = flc_pkg::MAX_TAPS_DEF - 1;
    localparam int  CYCLE_CAP  = 200000;
    localparam int  RAND_ITEMS = 80;
    localparam int  DRAIN_CAP  = 5000;
    // index 3 decodes to no register; writes there must be dropped
    localparam logic [flc_pkg::CFG_IDX_BITS-1:0] CFG_NO_REG = 2'd3;

    localparam logic [63:0] COEF_ALL_MIN = 64'h8000_8000_8000_8000;
    localparam logic [63:0] COEF_ALL_MAX = 64'h7FFF_7FFF_7FFF_7FFF;

    typedef struct packed {
        logic signed [flc_pkg::OUT_BITS-1:0] value;
        logic                                fin;
    } conv_out_t;

    // ------------------------------------------------------------------------
    // FIR predictor plus queue of expected results
    // ------------------------------------------------------------------------
    class conv_scoreboard;
        logic [flc_pkg::TAP_CNT_BITS-1:0] tap_count;
        logic [63:0]             coef_lo;
        logic [63:0]             coef_hi;
        longint                  history [HIST_DEPTH];
        conv_out_t               expected [$];
        int                      n_errors;
        int                      n_samples;
        int                      n_signals;
        int                      n_results;

        function new();
            tap_count = flc_pkg::TAP_CNT_BITS'(1);
            coef_lo   = '0;
            coef_hi   = '0;
            foreach (history[i]) history[i] = 0;
            n_errors  = 0;
            n_samples = 0;
            n_signals = 0;
            n_results = 0;
        endfunction

        function void write_reg(logic [flc_pkg::CFG_IDX_BITS-1:0] idx, logic [63:0] data);
            case (idx)
                flc_pkg::CFG_TAP_COUNT: tap_count = data[flc_pkg::TAP_CNT_BITS-1:0];
                flc_pkg::CFG_COEF_LOW:  coef_lo   = data;
                flc_pkg::CFG_COEF_HIGH: coef_hi   = data;
                default: ;
            endcase
        endfunction

        // zero counts as one tap, anything above the row length as all taps
        function int active_taps();
            if (tap_count == 0)
                return 1;
            if (tap_count > flc_pkg::MAX_TAPS_DEF)
                return flc_pkg::MAX_TAPS_DEF;
            return int'(tap_count);
        endfunction

        function longint coef_at(int k);
            logic [63:0]                          r;
            logic signed [flc_pkg::COEF_BITS-1:0] c;
            r = (k < flc_pkg::COEFS_PER_REG) ? coef_lo : coef_hi;
            c = r[(k % flc_pkg::COEFS_PER_REG) * flc_pkg::COEF_BITS +: flc_pkg::COEF_BITS];
            return longint'(c);
        endfunction

        // one output with cur at delay 0; the line always shifts its full depth
        function longint fir_tick(longint cur);
            longint acc;
            int     taps;
            taps = active_taps();
            acc  = coef_at(0) * cur;
            for (int k = 1; k < taps; k++)
                acc += coef_at(k) * history[k-1];
            for (int k = HIST_DEPTH - 1; k > 0; k--)
                history[k] = history[k-1];
            history[0] = cur;
            return acc;
        endfunction

        function void push_out(longint v, logic fin);
            conv_out_t e;
            e.value  = v[flc_pkg::OUT_BITS-1:0];
            e.fin    = fin;
            expected = {expected, e};
        endfunction

        function void note_sample(logic signed [flc_pkg::SAMPLE_BITS_DEF-1:0] s, logic fin);
            int taps;
            taps = active_taps();
            n_samples++;
            if (!fin) begin
                push_out(fir_tick(longint'(s)), 1'b0);
                return;
            end
            n_signals++;
            push_out(fir_tick(longint'(s)), taps == 1);
            for (int t = 1; t < taps; t++)
                push_out(fir_tick(0), t == taps - 1);
            foreach (history[i]) history[i] = 0;
        endfunction

        function void check_result(logic signed [flc_pkg::OUT_BITS-1:0] v, logic fin);
            conv_out_t e;
            n_results++;
            if (expected.size() == 0) begin
                $display("%0t: result with nothing expected, got %0d final %0b",
                         $time, v, fin);
                n_errors++;
                return;
            end
            e = expected.pop_front();
            if (e.value !== v) begin
                $display("%0t: conv_value mismatch, expected %0d, got %0d",
                         $time, $signed(e.value), v);
                n_errors++;
            end
            if (e.fin !== fin) begin
                $display("%0t: final_output mismatch, expected %0b, got %0b",
                         $time, e.fin, fin);
                n_errors++;
            end
        endfunction

        function int pending();
            return expected.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------------
    logic                                       clk;
    logic                                       rst_n;
    logic                                       cfg_valid;
    logic                                       cfg_ready;
    logic [flc_pkg::CFG_IDX_BITS-1:0]           cfg_index;
    logic [flc_pkg::CFG_DATA_BITS-1:0]          cfg_data;
    logic                                       in_valid;
    logic                                       in_ready;
    logic signed [flc_pkg::SAMPLE_BITS_DEF-1:0] sample;
    logic                                       final_sample;
    logic                                       out_valid;
    logic                                       out_ready;
    logic signed [flc_pkg::OUT_BITS-1:0]        conv_value;
    logic                                       final_output;

    full_linear_convolution dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .sample       (sample),
        .final_sample (final_sample),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .conv_value   (conv_value),
        .final_output (final_output)
    );

    conv_scoreboard sb;
    bit             idle_on;      // random gaps/stalls allowed right now
    int             n_settings;
    int             watchdog_cycles;

    // 12 ns clock
    initial clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Watchdog: ends a hung run as a failure.
    initial
    begin
        watchdog_cycles = 0;
        while (watchdog_cycles < CYCLE_CAP) begin
            @(posedge clk);
            watchdog_cycles++;
        end
        $display("timeout after %0d cycles, %0d results still expected",
                 watchdog_cycles, sb.pending());
        $display("Regression FAIL");
        $finish;
    end

    // Monitor: everything is sampled at the rising edge, before the NBAs of
    // this edge land, so handshakes are seen exactly as the DUT sees them.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (out_valid && out_ready)
                sb.check_result(conv_value, final_output);
            if (in_valid && in_ready)
                sb.note_sample(sample, final_sample);
        end
    end

    // Result side backpressure: random stall bursts while idling is on.
    initial
    begin
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            if (idle_on && $urandom_range(0, 3) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge clk);
            end
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    end

    // ------------------------------------------------------------------------
    // Driver tasks
    // ------------------------------------------------------------------------

    // Presents one item and returns at the edge that accepts it, leaving
    // in_valid high; the caller follows up in the same step with the next
    // item or with settle(), so a stale item is never taken twice.
    task automatic send_sample(input logic signed [flc_pkg::SAMPLE_BITS_DEF-1:0] s,
                               input logic fin);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        in_valid     <= 1'b1;
        sample       <= s;
        final_sample <= fin;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    // Stop sending and wait for the pipeline to empty.
    task automatic settle();
        int waited;
        waited = 0;
        in_valid <= 1'b0;
        while (sb.pending() != 0 && waited < DRAIN_CAP) begin
            @(posedge clk);
            waited++;
        end
        repeat (PIPE_LAT + 3) @(posedge clk);
    endtask

    task automatic write_reg(input logic [flc_pkg::CFG_IDX_BITS-1:0] idx,
                             input logic [flc_pkg::CFG_DATA_BITS-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        sb.write_reg(idx, data);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apply_setting(input logic [flc_pkg::TAP_CNT_BITS-1:0] taps,
                                 input logic [63:0] lo, input logic [63:0] hi);
        settle();
        write_reg(flc_pkg::CFG_TAP_COUNT,
                  {{(flc_pkg::CFG_DATA_BITS-flc_pkg::TAP_CNT_BITS){1'b0}}, taps});
        write_reg(flc_pkg::CFG_COEF_LOW, lo);
        write_reg(flc_pkg::CFG_COEF_HIGH, hi);
        n_settings++;
    endtask

    // extremes show up often, the rest is uniform
    function automatic logic signed [flc_pkg::SAMPLE_BITS_DEF-1:0] pick_sample();
        case ($urandom_range(0, 7))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2:       return '0;
            default: return flc_pkg::SAMPLE_BITS_DEF'($urandom);
        endcase
    endfunction

    function automatic logic [63:0] pick_coefs();
        case ($urandom_range(0, 9))
            0:       return COEF_ALL_MIN;
            1:       return COEF_ALL_MAX;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        int                               rand_sent;
        int                               len;
        int                               phase;
        logic [flc_pkg::TAP_CNT_BITS-1:0] taps;

        sb           = new();
        idle_on      = 1'b1;
        n_settings   = 0;
        rst_n        = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = flc_pkg::CFG_TAP_COUNT;
        cfg_data     = '0;
        in_valid     = 1'b0;
        sample       = '0;
        final_sample = 1'b0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // --- directed ---
        // reset config: one tap of zero, single tap signal gives one flagged result
        send_sample(16'sh7FFF, 1'b1);

        // tap count 0 saturates up to one tap; most negative squared
        apply_setting(4'd0, 64'h0000_0000_0000_8000, '0);
        send_sample(16'sh8000, 1'b1);

        // all eight taps at the most negative coefficient: largest positive sum
        apply_setting(4'd8, COEF_ALL_MIN, COEF_ALL_MIN);
        for (int i = 0; i < 8; i++)
            send_sample(16'sh8000, i == 7);

        // tap count above the row saturates down; largest coefficients
        apply_setting(4'd15, COEF_ALL_MAX, COEF_ALL_MAX);
        send_sample(16'sh7FFF, 1'b0);
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sh0001, 1'b0);
        send_sample(16'shFFFF, 1'b0);
        send_sample(16'sh0000, 1'b1);

        // tap count changed inside a signal; the delay line carries over
        apply_setting(4'd3, pick_coefs(), pick_coefs());
        send_sample(pick_sample(), 1'b0);
        send_sample(pick_sample(), 1'b0);
        send_sample(pick_sample(), 1'b0);
        apply_setting(4'd6, COEF_ALL_MAX, COEF_ALL_MIN);
        send_sample(pick_sample(), 1'b0);
        send_sample(pick_sample(), 1'b1);

        // a write to the unused index must leave the setting alone
        settle();
        write_reg(CFG_NO_REG, {$urandom, $urandom});
        send_sample(pick_sample(), 1'b0);
        send_sample(pick_sample(), 1'b1);

        // --- random signals ---
        // Phases of roughly a dozen items, each with a fresh setting. A phase may
        // end without a final item, which makes the next setting a mid signal
        // change. Phases begun with at most 15 items to go have no gaps or stalls.
        rand_sent = 0;
        phase     = 0;
        while (rand_sent < RAND_ITEMS) begin
            case (phase)
                0:       taps = 4'd8;
                1:       taps = 4'd1;
                2:       taps = 4'd15;
                default: taps = flc_pkg::TAP_CNT_BITS'($urandom_range(0, 15));
            endcase
            apply_setting(taps, pick_coefs(), pick_coefs());
            if (RAND_ITEMS - rand_sent <= 15)
                idle_on = 1'b0;
            else
                idle_on = ($urandom_range(0, 3) != 0);
            for (int n = 0; n < 12 && rand_sent < RAND_ITEMS; n += len) begin
                len = ($urandom_range(0, 5) == 0) ? 1 : $urandom_range(2, 12);
                for (int i = 0; i < len; i++) begin
                    // the very last item of a phase is sometimes left open
                    send_sample(pick_sample(), (i == len - 1) &&
                                ($urandom_range(0, 3) != 0 || n + len < 12));
                    rand_sent++;
                end
            end
            phase++;
        end
        // close any open signal so its tail is checked too
        send_sample(pick_sample(), 1'b1);

        // --- wrap up ---
        settle();
        if (sb.pending() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, sb.pending());
            sb.n_errors++;
        end
        $display("Run covered %0d samples in %0d complete signals and %0d results,",
                 sb.n_samples, sb.n_signals, sb.n_results);
        $display("over %0d register settings with %0d mismatches.",
                 n_settings, sb.n_errors);
        if (sb.n_errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
